FILE: design/sfc_pkg.sv
// sfc_pkg: shared types, constants and the CRC-16 byte update of the frame checker.
// No dependencies; imported by sfc_frame_ctl and serial_frame_checker_crc16_unit.
package sfc_pkg;

  localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
  localparam logic [7:0]  MIN_FRAME_COUNT    = 8'd6;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ERROR      = 2'd1,
    STATUS_UNEXPECTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FRAME = 2'b10
  } frame_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_t    frame_status;
    logic [7:0] frame_type;
  } out_item_t;

  // One byte of the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/sfc_frame_ctl.sv
// sfc_frame_ctl: frame tracking state, running CRC and the end-of-frame verdict.
// Depends on sfc_pkg (item types, status codes, crc16_byte).
module sfc_frame_ctl
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_item_t   item,
  input  logic [7:0] expected_type,
  output logic       res_valid,
  output out_item_t  res
);

  frame_state_t state, state_next;
  logic [8:0]   byte_count, byte_count_next;
  logic [7:0]   frame_length, frame_length_next;
  logic [7:0]   type_seen, type_seen_next;
  logic [15:0]  crc_accum, crc_accum_next;

  logic [15:0] crc_upd;
  logic [7:0]  type_now;
  logic        done;

  assign crc_upd  = crc16_byte(item.frame_start ? 16'h0000 : crc_accum, item.rx_byte);
  assign type_now = (byte_count == 9'd1) ? item.rx_byte : type_seen;
  assign done     = (byte_count + 9'd1) >= ({1'b0, frame_length} + 9'd1);

  always_comb begin
    state_next        = state;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    type_seen_next    = type_seen;
    crc_accum_next    = crc_accum;
    res_valid         = 1'b0;
    res.frame_status  = STATUS_OK;
    res.frame_type    = 8'h00;
    if (item.frame_start) begin
      // New count byte: drop any frame in progress.
      frame_length_next = item.rx_byte;
      type_seen_next    = 8'h00;
      if (item.rx_byte < MIN_FRAME_COUNT) begin
        state_next       = ST_IDLE;
        byte_count_next  = 9'd0;
        crc_accum_next   = 16'h0000;
        res_valid        = 1'b1;
        res.frame_status = STATUS_ERROR;
      end else begin
        state_next      = ST_FRAME;
        byte_count_next = 9'd1;
        crc_accum_next  = crc_upd;
      end
    end else begin
      case (state)
        ST_FRAME: begin
          crc_accum_next  = crc_upd;
          type_seen_next  = type_now;
          byte_count_next = byte_count + 9'd1;
          if (done) begin
            state_next     = ST_IDLE;
            res_valid      = 1'b1;
            res.frame_type = type_now;
            if (type_now != expected_type) begin
              res.frame_status = STATUS_UNEXPECTED;
            end else if (crc_upd != 16'h0000) begin
              res.frame_status = STATUS_ERROR;
            end else begin
              res.frame_status = STATUS_OK;
            end
          end
        end
        default: begin
          // Idle: ignore bytes outside a frame.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      byte_count   <= 9'd0;
      frame_length <= 8'h00;
      type_seen    <= 8'h00;
      crc_accum    <= 16'h0000;
    end else if (advance) begin
      state        <= state_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      type_seen    <= type_seen_next;
      crc_accum    <= crc_accum_next;
    end
  end

endmodule

FILE: design/serial_frame_checker_crc16_unit.sv
// serial_frame_checker_crc16_unit: top level of the CRC-16 serial frame checker.
// Depends on sfc_pkg and sfc_frame_ctl.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid / in_ready   | in_data  (rx_byte, frame_start)
//   out     | output    | out_valid / out_ready | out_data (frame_status, frame_type)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_data (expected_type)
//
// One byte per cycle sustained while the output is not stalled: a byte is held
// in the input register, the frame logic and the byte-wide CRC update run on it
// combinationally, and its result is captured in the output register on advance.
// Reset (rst, synchronous) empties both registers, returns the frame logic to
// idle and clears expected_type. A stalled output holds the byte in the input
// register only when it must; bytes that give no result never wait. The
// configuration port is always ready.
module serial_frame_checker_crc16_unit
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] expected_type;

  // Input register.
  logic      in_q_valid;
  in_item_t  in_q;

  // Frame logic results for the byte in the input register.
  logic      res_valid;
  out_item_t res;

  logic      out_free;
  logic      advance;

  // Advance the held byte unless it carries a result and the output is full.
  assign out_free = !out_valid || out_ready;
  assign advance  = in_q_valid && (out_free || !res_valid);
  assign in_ready = !in_q_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      expected_type <= cfg_data;
    end
  end

  // Load a new transaction whenever the input register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  sfc_frame_ctl u_frame_ctl (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (in_q),
    .expected_type (expected_type),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register: drop the result once taken, capture a new one on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  // A result appears only after a byte left the input register.
  a_rose_after_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without an advancing byte");

  // A short count byte reports a packet error with type zero on the next cycle.
  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && in_q.frame_start && (in_q.rx_byte < MIN_FRAME_COUNT)) |=>
      (out_valid && (out_data.frame_status == STATUS_ERROR) &&
       (out_data.frame_type == 8'h00)))
    else $error("short frame not reported");

  // Backpressure on the input only while a byte is held.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_q_valid)
    else $error("input stalled with empty input register");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for serial_frame_checker_crc16_unit.
// Holds a CRC-16 frame predictor and scoreboard class and the tasks that drive the block.
// Depends on sfc_pkg for the port types and status codes.
module tb
  import sfc_pkg::*;
();

  localparam int ITEMS_PER_PHASE = 270;
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_WAIT_LIMIT = 50000;

  // Predicts the frame checker byte by byte and holds the results still owed.
  class crc_frame_predictor;
    logic [7:0]  expected_type;
    bit          in_frame;
    logic [8:0]  byte_count;
    logic [7:0]  frame_length;
    logic [7:0]  type_seen;
    logic [15:0] crc_accum;
    out_item_t   owed_results[$];
    int          mismatches;
    int          status_hits[3];

    function new();
      expected_type = '0;
      in_frame      = 1'b0;
      byte_count    = '0;
      frame_length  = '0;
      type_seen     = '0;
      crc_accum     = '0;
      mismatches    = 0;
      status_hits   = '{0, 0, 0};
    endfunction

    // Shift one byte into the reflected CRC, one bit at a time, LSB first.
    static function logic [15:0] crc16_arc_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ data[i];
        c  = c >> 1;
        if (fb) c = c ^ 16'hA001;
      end
      return c;
    endfunction

    function void set_expected_type(logic [7:0] value);
      expected_type = value;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_byte(in_item_t item);
      out_item_t res;
      if (item.frame_start) begin
        // A count byte always drops whatever frame was open.
        in_frame     = 1'b0;
        type_seen    = '0;
        frame_length = item.rx_byte;
        if (item.rx_byte < MIN_FRAME_COUNT) begin
          byte_count = '0;
          crc_accum  = '0;
          res.frame_status = STATUS_ERROR;
          res.frame_type   = 8'h00;
          owed_results.push_back(res);
        end else begin
          in_frame   = 1'b1;
          byte_count = 9'd1;
          crc_accum  = crc16_arc_update(16'h0000, item.rx_byte);
        end
      end else if (in_frame) begin
        crc_accum = crc16_arc_update(crc_accum, item.rx_byte);
        if (byte_count == 9'd1) type_seen = item.rx_byte;
        byte_count = byte_count + 9'd1;
        if (byte_count >= {1'b0, frame_length} + 9'd1) begin
          in_frame = 1'b0;
          if (type_seen != expected_type) res.frame_status = STATUS_UNEXPECTED;
          else if (crc_accum != 16'h0000) res.frame_status = STATUS_ERROR;
          else res.frame_status = STATUS_OK;
          res.frame_type = type_seen;
          owed_results.push_back(res);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d type=%02h", $time,
                 got.frame_status, got.frame_type);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (got.frame_status != want.frame_status) begin
        $display("%0t: frame_status expected %0d actual %0d", $time,
                 want.frame_status, got.frame_status);
        mismatches++;
      end
      if (got.frame_type != want.frame_type) begin
        $display("%0t: frame_type expected %02h actual %02h", $time,
                 want.frame_type, got.frame_type);
        mismatches++;
      end
      if (want.frame_status <= STATUS_UNEXPECTED) status_hits[want.frame_status]++;
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  crc_frame_predictor frames;

  int         burst_left;
  int         bytes_sent;
  int         frames_sent;
  int         type_settings;
  logic [7:0] active_type;

  serial_frame_checker_crc16_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall on a random duty pattern that is reshuffled as rx_tick runs.
  // A stall length of zero gives stretches with the output always ready.
  int rx_tick;
  int rx_period;
  int rx_stall;
  always @(negedge clk) begin
    if (rst) begin
      rx_tick   <= 0;
      rx_period <= 4;
      rx_stall  <= 0;
      out_ready <= 1'b1;
    end else begin
      if (rx_tick % 200 == 199) begin
        rx_period <= $urandom_range(1, 12);
        rx_stall  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      rx_tick   <= rx_tick + 1;
      out_ready <= ((rx_tick % rx_period) >= rx_stall);
    end
  end

  // Check every result transaction against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) frames.check_result(out_data);
  end

  // Offer one byte and hold it until the transaction completes. Enter and leave
  // at a falling edge; valid stays high across a burst.
  task automatic send_byte(logic [7:0] b, bit start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    in_valid              = 1'b1;
    in_data.rx_byte       = b;
    in_data.frame_start   = start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames.note_byte(in_data);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Build a frame with a valid trailing CRC, optionally flip one bit after the
  // type byte, and send it. cut >= 0 abandons the frame after cut bytes past the count.
  task automatic send_frame(logic [7:0] count, logic [7:0] ptype, bit corrupt, int cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          pos;
    body.push_back(count);
    if (count >= MIN_FRAME_COUNT) begin
      body.push_back(ptype);
      for (int i = 0; i < int'(count) - 3; i++) body.push_back(8'($urandom));
      crc = 16'h0000;
      foreach (body[i]) crc = crc_frame_predictor::crc16_arc_update(crc, body[i]);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      if (corrupt) begin
        pos = $urandom_range(2, body.size() - 1);
        body[pos][$urandom_range(0, 7)] ^= 1'b1;
      end
    end
    if (cut >= 0 && cut + 1 < body.size()) body = body[0:cut];
    foreach (body[i]) send_byte(body[i], i == 0);
    frames_sent++;
  endtask

  // Drop valid and hold until every owed result has been taken, then let the
  // pipeline settle so a byte with no result is surely done.
  task automatic wait_for_idle();
    int waited;
    in_valid   = 1'b0;
    burst_left = 0;
    waited     = 0;
    while (frames.pending() != 0 && waited < IDLE_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_expected_type(logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frames.set_expected_type(value);
    active_type = value;
    type_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 199);
    if (r < 2) return 8'hFF;
    if (r < 20) return 8'($urandom_range(21, 80));
    return 8'($urandom_range(6, 20));
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return active_type;
    if (r < 75) return 8'h00;
    if (r < 80) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise.
  task automatic run_random_phase(int n_items);
    int         start_bytes;
    int         kind;
    logic [7:0] cnt;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(pick_count(), pick_type(), 1'b0, -1);
      end else if (kind < 70) begin
        send_frame(pick_count(), pick_type(), 1'b1, -1);
      end else if (kind < 80) begin
        send_frame(8'($urandom_range(0, 5)), 8'h00, 1'b0, -1);
      end else if (kind < 88) begin
        // Abandon a frame part way; the next count byte restarts framing.
        cnt = pick_count();
        send_frame(cnt, pick_type(), 1'b0, $urandom_range(0, int'(cnt) - 1));
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else if (!frames.in_frame) begin
        // Stray bytes between frames are ignored; keep them off the item budget.
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom), 1'b0);
          start_bytes++;
        end
      end
    end
  endtask

  initial begin
    frames        = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_ready     = 1'b0;
    burst_left    = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    type_settings = 0;
    active_type   = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: expected_type still at its reset value of zero.
    send_frame(8'h00, 8'h00, 1'b0, -1);          // shortest count, error at once
    send_frame(8'h05, 8'h00, 1'b0, -1);          // largest short count
    send_byte(8'h00, 1'b0);                      // ignored while idle
    send_byte(8'hFF, 1'b0);
    send_frame(8'h06, 8'h00, 1'b0, -1);          // minimum legal frame, clean
    send_frame(8'h07, 8'h00, 1'b0, 2);           // dropped by the next count byte
    send_frame(8'h06, 8'hFF, 1'b1, -1);          // wrong type and bad CRC: unexpected
    wait_for_idle();

    // Random phases across several expected_type settings, extremes included.
    write_expected_type(8'hFF);
    send_frame(8'hFF, 8'hFF, 1'b0, -1);          // longest frame once
    run_random_phase(ITEMS_PER_PHASE);
    wait_for_idle();
    write_expected_type(8'($urandom_range(1, 254)));
    run_random_phase(ITEMS_PER_PHASE);
    wait_for_idle();
    write_expected_type(8'h00);
    run_random_phase(ITEMS_PER_PHASE);
    wait_for_idle();

    if (frames.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, frames.pending());
      frames.mismatches++;
    end
    $display("Covered %0d bytes in %0d frames over %0d expected_type settings.",
             bytes_sent, frames_sent, type_settings);
    $display("Results checked: %0d ok, %0d error, %0d unexpected type; %0d mismatches.",
             frames.status_hits[0], frames.status_hits[1], frames.status_hits[2],
             frames.mismatches);
    if (frames.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: serial_frame_checker_crc16_unit.f
design/sfc_pkg.sv
design/sfc_frame_ctl.sv
design/serial_frame_checker_crc16_unit.sv
tb/tb.sv
